// ----- hw/rtl/cswg_pkg.sv -----
// Shared types, constants and the polynomial step for the cosine-sum window generator.
`timescale 1ns / 1ps
package cswg_pkg;

	localparam int COEF_REGS = 6;
	localparam int LEN_W     = 17;
	localparam int QUOT_W    = 17;
	localparam int COEF_W    = 16;
	localparam int TERM_W    = 17;
	localparam int OUT_W     = 19;

	// Register indexes on the configuration port.
	localparam logic [2:0] REG_WINDOW_LENGTH = 3'd0;
	localparam logic [2:0] REG_TERM_COUNT    = 3'd1;
	localparam logic [2:0] REG_COEFF_ZERO    = 3'd2;

	// Cosine polynomial coefficients, Q30.
	localparam logic [30:0] ONE_Q30 = 31'd1073741824;
	localparam logic [30:0] COS_C1  = 31'd1324675879;
	localparam logic [30:0] COS_C2  = 31'd272375560;
	localparam logic [30:0] COS_C3  = 31'd22401992;
	localparam logic [30:0] COS_C4  = 31'd987048;
	localparam logic [30:0] COS_C5  = 31'd27060;

	typedef struct packed {
		logic valid;
		logic beyond;
	} meta_t;

	// c - floor(z*t / 2^30), clamped at zero
	function automatic logic [30:0] horner_step(input logic [30:0] c, input logic [30:0] z,
			input logic [30:0] t);
		logic [61:0] prod;
		logic [31:0] p;
		prod = 62'(z) * 62'(t);
		p = prod[61:30];
		return (p >= {1'b0, c}) ? 31'd0 : 31'({1'b0, c} - p);
	endfunction

endpackage

// ----- hw/rtl/cswg_div.sv -----
// Pipelined restoring divider: (d * 2^16) / len, one quotient bit per stage.
`timescale 1ns / 1ps
module cswg_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cswg_pkg::meta_t              meta_in,
	input  logic [cswg_pkg::LEN_W-1:0]   d,
	input  logic [cswg_pkg::LEN_W-1:0]   len_in,
	output cswg_pkg::meta_t              meta_out,
	output logic [cswg_pkg::QUOT_W-1:0]  quot,
	output logic [cswg_pkg::LEN_W-1:0]   rem,
	output logic [cswg_pkg::LEN_W-1:0]   len_out
);
	localparam int QW = cswg_pkg::QUOT_W;
	localparam int LW = cswg_pkg::LEN_W;

	cswg_pkg::meta_t meta_a [QW+1];
	logic [LW-1:0]   rem_a  [QW+1];
	logic [QW-1:0]   quot_a [QW+1];
	logic [LW-1:0]   len_a  [QW+1];

	// for in-window items d <= len, so d/2 is already below the divisor
	assign meta_a[0] = meta_in;
	assign rem_a[0]  = {1'b0, d[LW-1:1]};
	assign quot_a[0] = '0;
	assign len_a[0]  = len_in;

	genvar k;
	generate
		for (k = 0; k < QW; k++) begin : g_stage
			logic [LW:0] shifted;
			logic        take;
			assign shifted = {rem_a[k], (k == 0) ? d[0] : 1'b0};
			assign take    = shifted >= {1'b0, len_a[k]};
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					meta_a[k+1] <= '0;
				end else begin
					meta_a[k+1] <= meta_a[k];
				end
			end
			always_ff @(posedge clk) begin
				rem_a[k+1]  <= take ? LW'(shifted - {1'b0, len_a[k]}) : shifted[LW-1:0];
				quot_a[k+1] <= {quot_a[k][QW-2:0], take};
				len_a[k+1]  <= len_a[k];
			end
		end
	endgenerate

	assign meta_out = meta_a[QW];
	assign quot     = quot_a[QW];
	assign rem      = rem_a[QW];
	assign len_out  = len_a[QW];

endmodule

// ----- hw/rtl/cswg_lane.sv -----
// One cosine term: phase, polynomial cosine and rounded coefficient product.
`timescale 1ns / 1ps
module cswg_lane #(
	parameter int IDX = 0
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cswg_pkg::meta_t                     meta_in,
	input  logic [cswg_pkg::QUOT_W-1:0]         quot,
	input  logic [cswg_pkg::LEN_W-1:0]          rem,
	input  logic [cswg_pkg::LEN_W-1:0]          len,
	input  logic signed [cswg_pkg::COEF_W-1:0]  coeff,
	output cswg_pkg::meta_t                     meta_out,
	output logic signed [cswg_pkg::TERM_W-1:0]  term
);
	localparam int TERM_W_L = cswg_pkg::TERM_W;

	cswg_pkg::meta_t m_s1, m_s2, m_s3, m_s4, m_s5, m_s6, m_s7, m_s8, m_s9, m_s10, m_s11;
	logic [16:0]        ph_s1;
	logic [15:0]        p_s2;
	logic               neg_s2, neg_s3, neg_s4, neg_s5, neg_s6, neg_s7, neg_s8;
	logic [30:0]        z_s3, z_s4, z_s5, z_s6, z_s7;
	logic [30:0]        t_s4, t_s5, t_s6, t_s7, t_s8;
	logic signed [15:0] cos_s9;
	logic signed [31:0] prod_s10;
	logic signed [TERM_W_L-1:0] term_s11;

	// phase = IDX*quot + IDX*rem/len rounded to nearest, ties up
	logic [24:0] rr;
	logic [3:0]  frac_c;
	logic [19:0] ph_c;
	always_comb begin
		rr = 25'(rem) * 25'(2 * IDX);
		frac_c = '0;
		for (int j = 1; j <= IDX; j++) begin
			if (rr >= 25'(len) * 25'(2 * j - 1)) frac_c = frac_c + 4'd1;
		end
		ph_c = 20'(quot) * 20'(IDX) + 20'(frac_c);
	end

	// fold onto the first quadrant
	logic [16:0] f1;
	logic [16:0] f2;
	logic        neg_c;
	always_comb begin
		f1 = (ph_s1 > 17'd65536) ? 17'(18'd131072 - 18'(ph_s1)) : ph_s1;
		neg_c = f1 > 17'd32768;
		f2 = neg_c ? 17'(17'd65536 - f1) : f1;
	end

	logic [14:0] mag_c;
	assign mag_c = 15'((32'(t_s8) + 32'd32768) >> 16);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_s1 <= '0; m_s2 <= '0; m_s3 <= '0; m_s4 <= '0; m_s5 <= '0; m_s6 <= '0;
			m_s7 <= '0; m_s8 <= '0; m_s9 <= '0; m_s10 <= '0; m_s11 <= '0;
		end else begin
			m_s1 <= meta_in; m_s2 <= m_s1; m_s3 <= m_s2; m_s4 <= m_s3; m_s5 <= m_s4;
			m_s6 <= m_s5; m_s7 <= m_s6; m_s8 <= m_s7; m_s9 <= m_s8; m_s10 <= m_s9;
			m_s11 <= m_s10;
		end
	end

	always_ff @(posedge clk) begin
		ph_s1  <= ph_c[16:0];
		p_s2   <= f2[15:0];
		neg_s2 <= neg_c;
		z_s3   <= 31'(32'(p_s2) * 32'(p_s2));
		neg_s3 <= neg_s2;
		t_s4   <= cswg_pkg::horner_step(cswg_pkg::COS_C4, z_s3, cswg_pkg::COS_C5);
		z_s4   <= z_s3;
		neg_s4 <= neg_s3;
		t_s5   <= cswg_pkg::horner_step(cswg_pkg::COS_C3, z_s4, t_s4);
		z_s5   <= z_s4;
		neg_s5 <= neg_s4;
		t_s6   <= cswg_pkg::horner_step(cswg_pkg::COS_C2, z_s5, t_s5);
		z_s6   <= z_s5;
		neg_s6 <= neg_s5;
		t_s7   <= cswg_pkg::horner_step(cswg_pkg::COS_C1, z_s6, t_s6);
		z_s7   <= z_s6;
		neg_s7 <= neg_s6;
		t_s8   <= cswg_pkg::horner_step(cswg_pkg::ONE_Q30, z_s7, t_s7);
		neg_s8 <= neg_s7;
		cos_s9 <= neg_s8 ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});
		prod_s10 <= ((IDX % 2) == 1) ? -(32'(coeff) * 32'(cos_s9)) : 32'(coeff) * 32'(cos_s9);
		term_s11 <= TERM_W_L'((prod_s10 + 32'sd8192) >>> 14);
	end

	assign meta_out = m_s11;
	assign term     = term_s11;

endmodule

// ----- hw/rtl/cosine_sum_window_generator_top.sv -----
// Top level of the generalized cosine-sum window generator.
`timescale 1ns / 1ps
// Pulse start with sample_index while busy is low (busy never rises) and one
// item enters per clock. Each item returns exactly one result, window_value
// (Q4.14) and index_beyond, on a one-cycle done strobe; there is no
// backpressure, so take the result when done is high. The item passes through
// the 17-stage pipelined divider that forms |2n-N|/N and the 11-stage cosine
// lanes, one lane per term working side by side.
// Configuration writes (cfg_we, cfg_index, cfg_data) act at once and should
// only be made while no items are in flight.
module cosine_sum_window_generator_top #(
	parameter int MAX_TERMS  = 6,
	parameter int MAX_LENGTH = 65536
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [15:0]        sample_index,
	output logic               done,
	output logic signed [18:0] window_value,
	output logic               index_beyond,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [16:0]        cfg_data
);
	localparam int LANES = (MAX_TERMS < cswg_pkg::COEF_REGS) ? MAX_TERMS : cswg_pkg::COEF_REGS;
	localparam int LW    = cswg_pkg::LEN_W;

	// configuration registers
	logic [LW-1:0]             window_length_q;
	logic [2:0]                term_count_q;
	logic signed [15:0]        coeff_q [cswg_pkg::COEF_REGS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q <= 17'd1024;
			term_count_q    <= 3'd2;
			for (int i = 0; i < cswg_pkg::COEF_REGS; i++) coeff_q[i] <= '0;
			coeff_q[0] <= 16'sd8192;
			coeff_q[1] <= -16'sd8192;
		end else if (cfg_we) begin
			case (cfg_index)
				cswg_pkg::REG_WINDOW_LENGTH: window_length_q <= cfg_data;
				cswg_pkg::REG_TERM_COUNT:    term_count_q <= cfg_data[2:0];
				default: coeff_q[3'(cfg_index - cswg_pkg::REG_COEFF_ZERO)] <= cfg_data[15:0];
			endcase
		end
	end

	assign busy = 1'b0;

	// s1: capture the item
	logic        v_s1;
	logic [15:0] n_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else         v_s1 <= start && !busy;
	end
	always_ff @(posedge clk) n_s1 <= sample_index;

	// s2: clamp length, range check, distance from the window center
	logic [LW-1:0] len_c, twon_c;
	always_comb begin
		len_c  = (32'(window_length_q) > 32'(MAX_LENGTH)) ? LW'(MAX_LENGTH) : window_length_q;
		twon_c = {n_s1, 1'b0};
	end

	cswg_pkg::meta_t m_s2;
	logic [LW-1:0]   d_s2, len_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_s2 <= '0;
		else         m_s2 <= '{valid: v_s1, beyond: {1'b0, n_s1} >= len_c};
	end
	always_ff @(posedge clk) begin
		d_s2   <= (twon_c >= len_c) ? twon_c - len_c : len_c - twon_c;
		len_s2 <= len_c;
	end

	// divider
	cswg_pkg::meta_t   m_div;
	logic [LW-1:0]     quot_div, rem_div, len_div;
	cswg_div u_div (
		.clk(clk), .arst_n(arst_n), .meta_in(m_s2), .d(d_s2), .len_in(len_s2),
		.meta_out(m_div), .quot(quot_div), .rem(rem_div), .len_out(len_div)
	);

	// one lane per term
	cswg_pkg::meta_t m_lane [LANES];
	logic signed [cswg_pkg::TERM_W-1:0] term_lane [LANES];
	genvar g;
	generate
		for (g = 0; g < LANES; g++) begin : g_lane
			cswg_lane #(.IDX(g)) u_lane (
				.clk(clk), .arst_n(arst_n), .meta_in(m_div), .quot(quot_div),
				.rem(rem_div), .len(len_div), .coeff(coeff_q[g]),
				.meta_out(m_lane[g]), .term(term_lane[g])
			);
		end
	endgenerate

	// sum of the active terms
	logic [2:0]         k_c;
	logic signed [20:0] sum_c;
	always_comb begin
		k_c = (term_count_q > 3'(LANES)) ? 3'(LANES) : term_count_q;
		sum_c = '0;
		for (int i = 0; i < LANES; i++) begin
			if (3'(i) < k_c) sum_c = sum_c + 21'(term_lane[i]);
		end
	end

	logic signed [20:0] sum_s3;
	cswg_pkg::meta_t    m_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_s3 <= '0;
		else         m_s3 <= m_lane[0];
	end
	always_ff @(posedge clk) sum_s3 <= sum_c;

	// output register: saturate, force zero beyond the window
	logic signed [18:0] sat_c;
	always_comb begin
		if (sum_s3 > 21'sd262143)       sat_c = 19'sd262143;
		else if (sum_s3 < -21'sd262144) sat_c = -19'sd262144;
		else                            sat_c = sum_s3[18:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else         done <= m_s3.valid;
	end
	always_ff @(posedge clk) begin
		window_value <= m_s3.beyond ? 19'sd0 : sat_c;
		index_beyond <= m_s3.beyond;
	end

	a_beyond_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && index_beyond |-> window_value == 19'sd0)
		else $error("beyond item with nonzero value");
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		m_s3.valid |=> done)
		else $error("done strobe lost");
	a_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		m_lane[0].valid == m_lane[LANES-1].valid)
		else $error("term lanes out of step");

endmodule

// ----- sim/cosine_sum_window_generator_top_tb.sv -----
// Self-checking testbench for the cosine-sum window generator top level.
`timescale 1ns / 1ps
module cosine_sum_window_generator_top_tb;

	localparam int MAX_TERMS  = 6;
	localparam int MAX_LENGTH = 65536;
	localparam int LATENCY    = 32;
	localparam int WATCHDOG   = 20000;
	localparam int RANDOM_ITEMS = 1550;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [15:0]       sample_index;
	logic              done;
	logic signed [18:0] window_value;
	logic              index_beyond;
	logic              cfg_we;
	logic [2:0]        cfg_index;
	logic [16:0]       cfg_data;

	cosine_sum_window_generator_top #(
		.MAX_TERMS (MAX_TERMS),
		.MAX_LENGTH(MAX_LENGTH)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.sample_index(sample_index),
		.done        (done),
		.window_value(window_value),
		.index_beyond(index_beyond),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	typedef struct {
		logic signed [18:0] value;
		logic               beyond;
	} weight_t;

	// Testbench copy of the register file
	logic [16:0]        shadow_length;
	logic [2:0]         shadow_terms;
	logic signed [15:0] shadow_coef [cswg_pkg::COEF_REGS];

	weight_t pending_weights[$];
	int      errors;
	int      idle_cycles;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Q30 Horner step: c - floor(z*t/2^30), floored at zero
	function automatic longint unsigned poly_step(longint unsigned c, longint unsigned z,
			longint unsigned t);
		longint unsigned p;
		p = (z * t) >> 30;
		return (p >= c) ? 64'd0 : c - p;
	endfunction

	// Cosine of a phase in half-turns with 16 fraction bits, Q1.14 out
	function automatic int cos_half_turns(longint unsigned phase);
		longint unsigned p, z, t;
		bit neg;
		p = phase & 64'h1FFFF;
		neg = 1'b0;
		if (p > 65536) p = 131072 - p;
		if (p > 32768) begin
			p = 65536 - p;
			neg = 1'b1;
		end
		z = p * p;
		t = poly_step(64'(cswg_pkg::COS_C4), z, 64'(cswg_pkg::COS_C5));
		t = poly_step(64'(cswg_pkg::COS_C3), z, t);
		t = poly_step(64'(cswg_pkg::COS_C2), z, t);
		t = poly_step(64'(cswg_pkg::COS_C1), z, t);
		t = poly_step(64'(cswg_pkg::ONE_Q30), z, t);
		t = (t + 32768) >> 16;
		return neg ? -int'(t) : int'(t);
	endfunction

	// Q2.28 to Q14, ties toward +inf
	function automatic longint round_term(longint v);
		longint b;
		b = v + 8192;
		if (b >= 0) return b >>> 14;
		return -((-b + 16383) >>> 14);
	endfunction

	function automatic weight_t window_weight(logic [15:0] n);
		weight_t w;
		longint unsigned len, d, ph;
		int k;
		longint sum, prod;
		len = shadow_length;
		if (len > MAX_LENGTH) len = MAX_LENGTH;
		if (n >= len) begin
			w.value = '0;
			w.beyond = 1'b1;
			return w;
		end
		k = shadow_terms;
		if (k > MAX_TERMS) k = MAX_TERMS;
		if (k > cswg_pkg::COEF_REGS) k = cswg_pkg::COEF_REGS;
		d = (2 * n >= len) ? 2 * n - len : len - 2 * n;
		sum = 0;
		for (int i = 0; i < k; i++) begin
			ph = (longint'(i) * d * 131072 + len) / (2 * len);
			prod = longint'(shadow_coef[i]) * longint'(cos_half_turns(ph));
			if (i % 2) prod = -prod;
			sum += round_term(prod);
		end
		if (sum > 262143) sum = 262143;
		if (sum < -262144) sum = -262144;
		w.value = sum[18:0];
		w.beyond = 1'b0;
		return w;
	endfunction

	// Result checker: every done strobe pops the oldest expectation
	always @(posedge clk) begin
		weight_t want;
		if (done) begin
			if (pending_weights.size() == 0) begin
				$display("%0t: unexpected result value=%0d beyond=%0b", $time,
					window_value, index_beyond);
				errors++;
			end else begin
				want = pending_weights.pop_front();
				if (window_value !== want.value) begin
					$display("%0t: window_value expected %0d actual %0d", $time,
						want.value, window_value);
					errors++;
				end
				if (index_beyond !== want.beyond) begin
					$display("%0t: index_beyond expected %0b actual %0b", $time,
						want.beyond, index_beyond);
					errors++;
				end
			end
		end
	end

	// Watchdog on cycles where no item moves either way
	always @(posedge clk) begin
		if (!arst_n || done || (start && !busy)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// One register write; cfg_we is low again when the task returns
	task automatic write_reg(logic [2:0] idx, logic [16:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			cswg_pkg::REG_WINDOW_LENGTH: shadow_length = val;
			cswg_pkg::REG_TERM_COUNT:    shadow_terms = val[2:0];
			default:           shadow_coef[idx - cswg_pkg::REG_COEFF_ZERO] = val[15:0];
		endcase
		@(posedge clk);
	endtask

	// Wait for the pipeline to drain before touching registers
	task automatic drain();
		while (pending_weights.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// Gap length in cycles: mostly none or short, a few long
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Offer one item; start stays high across back-to-back items
	task automatic send_index(logic [15:0] n, bit check_fixed, weight_t fixed, bit gaps);
		weight_t w;
		int g;
		start        <= 1'b1;
		sample_index <= n;
		@(posedge clk);
		while (busy) @(posedge clk);
		w = window_weight(n);
		if (check_fixed && (w.value !== fixed.value || w.beyond !== fixed.beyond))
			$display("%0t: table row for index %0d disagrees with predictor", $time, n);
		pending_weights.push_back(check_fixed ? fixed : w);
		if (gaps && ($urandom_range(0, 1) == 0)) begin
			g = gap_len();
			if (g > 0) begin
				start <= 1'b0;
				repeat (g) @(posedge clk);
			end
		end
	endtask

	// Directed rows; "fixed" rows carry a hand-written expectation
	typedef struct {
		logic [15:0]        n;
		bit                 fixed;
		logic signed [18:0] value;
		logic               beyond;
	} row_t;

	row_t rows[] = '{
		'{16'd0,     1, 19'sd0,     1'b0},   // Hann edge
		'{16'd512,   1, 19'sd16384, 1'b0},   // Hann center is one
		'{16'd256,   0, 19'sd0,     1'b0},
		'{16'd768,   0, 19'sd0,     1'b0},
		'{16'd1,     0, 19'sd0,     1'b0},
		'{16'd1023,  0, 19'sd0,     1'b0},
		'{16'd1024,  1, 19'sd0,     1'b1},   // first index past the end
		'{16'd65535, 1, 19'sd0,     1'b1},
		'{16'd511,   0, 19'sd0,     1'b0},
		'{16'd513,   0, 19'sd0,     1'b0}
	};

	task automatic random_config();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: write_reg(cswg_pkg::REG_WINDOW_LENGTH, 17'd65536);
			1: write_reg(cswg_pkg::REG_WINDOW_LENGTH, 17'h1FFFF);      // clamps to max
			2: write_reg(cswg_pkg::REG_WINDOW_LENGTH, 17'd1);
			3: write_reg(cswg_pkg::REG_WINDOW_LENGTH, 17'd0);
			default: write_reg(cswg_pkg::REG_WINDOW_LENGTH, 17'($urandom_range(2, 70000)));
		endcase
		write_reg(cswg_pkg::REG_TERM_COUNT, 17'($urandom_range(0, 7)));
		for (int i = 0; i < cswg_pkg::COEF_REGS; i++) begin
			r = $urandom_range(0, 5);
			write_reg(cswg_pkg::REG_COEFF_ZERO + 3'(i), r == 0 ? 17'h08000 :
				r == 1 ? 17'h07FFF : 17'($urandom()));
		end
	endtask

	initial begin
		weight_t w;
		logic [15:0] n;
		int len;
		errors       = 0;
		arst_n       = 1'b0;
		start        = 1'b0;
		sample_index = '0;
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		shadow_length = 17'd1024;
		shadow_terms  = 3'd2;
		foreach (shadow_coef[i]) shadow_coef[i] = '0;
		shadow_coef[0] = 16'sd8192;
		shadow_coef[1] = -16'sd8192;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset Hann window, back to back
		foreach (rows[i]) begin
			w.value  = rows[i].value;
			w.beyond = rows[i].beyond;
			send_index(rows[i].n, rows[i].fixed, w, 1'b0);
		end
		start <= 1'b0;
		drain();

		// Directed: extreme coefficients, all six terms, max length
		write_reg(cswg_pkg::REG_WINDOW_LENGTH, 17'd65536);
		write_reg(cswg_pkg::REG_TERM_COUNT, 17'd6);
		for (int i = 0; i < cswg_pkg::COEF_REGS; i++)
			write_reg(cswg_pkg::REG_COEFF_ZERO + 3'(i), (i % 2) ? 17'h08000 : 17'h07FFF);
		send_index(16'd0, 0, w, 0);
		send_index(16'd32768, 0, w, 0);
		send_index(16'd65535, 0, w, 0);
		send_index(16'd16384, 0, w, 0);
		start <= 1'b0;
		drain();
		// Zero terms, too many terms, zero length, then an over-range length
		write_reg(cswg_pkg::REG_TERM_COUNT, 17'd0);
		w.value = '0;
		w.beyond = 1'b0;
		send_index(16'd100, 1, w, 0);
		start <= 1'b0;
		drain();
		write_reg(cswg_pkg::REG_TERM_COUNT, 17'd7);
		send_index(16'd12345, 0, w, 0);
		start <= 1'b0;
		drain();
		write_reg(cswg_pkg::REG_WINDOW_LENGTH, 17'd0);
		w.beyond = 1'b1;
		send_index(16'd0, 1, w, 0);
		start <= 1'b0;
		drain();
		write_reg(cswg_pkg::REG_WINDOW_LENGTH, 17'h1FFFF);
		send_index(16'd65535, 0, w, 0);
		start <= 1'b0;
		drain();

		// Random phases; a fresh register setting every 100 items
		for (int item = 0; item < RANDOM_ITEMS; item++) begin
			if (item % 100 == 0) begin
				start <= 1'b0;
				drain();
				random_config();
			end
			len = (shadow_length > MAX_LENGTH) ? MAX_LENGTH : shadow_length;
			// Mostly in-window indices; some anywhere to hit the beyond flag
			if ($urandom_range(0, 9) < 8 && len > 0)
				n = 16'($urandom_range(0, (len > 65536 ? 65536 : len) - 1));
			else
				n = 16'($urandom());
			send_index(n, 0, w, 1'b1);
			// Sender pause until everything is back
			if (item == 700) begin
				start <= 1'b0;
				while (pending_weights.size() != 0) @(posedge clk);
			end
		end
		start <= 1'b0;

		while (pending_weights.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
		if (errors == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end

endmodule
